// ----- sv/assert_macros.svh -----
// Assertion macros used by the top-level RTL of the wheel pulse rate remapper.
// Standalone header; no other file is needed.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge while out of reset.
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Checks that the consequent holds in the clock cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/wprr_pkg.sv -----
// Package of the wheel pulse rate remapper: widths, register codes, state types.
// Used by wprr_remap, wheel_pulse_rate_remapper and tb_top; depends on nothing.
package wprr_pkg;

  // Tick counter and interval widths.
  localparam int unsigned TIME_BITS = 32;
  localparam int unsigned MEAS_W    = 32;
  localparam int unsigned NEXT_W    = 32;

  // Configuration register widths.
  localparam int unsigned WHEEL_W    = 12;
  localparam int unsigned SLOW_W     = 16;
  localparam int unsigned DEBOUNCE_W = 10;
  localparam int unsigned IDLE_W     = 16;
  localparam int unsigned PULSE_W    = 8;
  localparam int unsigned HOLD_W     = 22;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Register reset values.
  localparam logic [WHEEL_W-1:0]    WHEEL_RST    = WHEEL_W'(2360);
  localparam logic [SLOW_W-1:0]     SLOW_RST     = SLOW_W'(383);
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = DEBOUNCE_W'(100);
  localparam logic [IDLE_W-1:0]     IDLE_RST     = IDLE_W'(4000);
  localparam logic [PULSE_W-1:0]    PULSE_RST    = PULSE_W'(2);
  localparam logic [HOLD_W-1:0]     HOLD_RST     = HOLD_W'(900000);
  localparam logic [NEXT_W-1:0]     NEXT_RST     = NEXT_W'(999999);

  // Remap arithmetic: q = 360*W*I / (36*W + 2000*I).
  // The quotient is below 0.18*W, so ten quotient bits always suffice.
  localparam int unsigned Q_BITS  = 10;
  localparam int unsigned MCAND_W = 21;                   // 360*W
  localparam int unsigned DEN_W   = 43;                   // 36*W + 2000*I
  localparam int unsigned REM_W   = MCAND_W + 1 + MEAS_W; // product register
  localparam int unsigned CNT_W   = $clog2(MEAS_W);
  localparam int unsigned WHEEL_SCALE = 360;
  localparam int unsigned DEN_W_SCALE = 36;
  localparam int unsigned DEN_I_SCALE = 2000;

  // Stream payload widths.
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_FIELD_W = 1 + 2 + MEAS_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WHEEL_MM    = 3'd0,
    CFG_SLOW_MS     = 3'd1,
    CFG_DEBOUNCE_MS = 3'd2,
    CFG_IDLE_MS     = 3'd3,
    CFG_PULSE_MS    = 3'd4,
    CFG_HOLD_OFF_MS = 3'd5
  } cfg_index_e;

  typedef enum logic [1:0] {
    LAMP_GREEN = 2'd0,
    LAMP_BLUE  = 2'd1,
    LAMP_RED   = 2'd2
  } lamp_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_WAIT,
    S_DUE
  } tick_state_e;

  typedef enum logic [1:0] {
    R_IDLE,
    R_MUL,
    R_DIV,
    R_DONE
  } remap_state_e;

endpackage

// ----- sv/wprr_remap.sv -----
// Serial remap unit: 360*W*I / (36*W + 2000*I), truncated.
// A shift-add multiplier (one multiplier bit per cycle) feeds a restoring divider
// (one quotient bit per cycle). Depends on wprr_pkg.
module wprr_remap import wprr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [WHEEL_W-1:0] wheel_mm_i,
  input  logic [MEAS_W-1:0]  interval_i,
  output logic               done_o,
  output logic [Q_BITS-1:0]  quotient_o
);

  remap_state_e         state_q, state_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [MCAND_W-1:0]   mcand_q, mcand_d;
  logic [MCAND_W:0]     acc_q, acc_d;
  logic [MEAS_W-1:0]    mplr_q, mplr_d;
  logic [DEN_W-1:0]     den_q, den_d;
  logic [REM_W-1:0]     rem_q, rem_d;
  logic [REM_W-1:0]     dsh_q, dsh_d;
  logic [Q_BITS-1:0]    quo_q, quo_d;
  logic [MCAND_W:0]     sum;
  logic                 ge;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= R_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    mcand_q <= mcand_d;
    acc_q   <= acc_d;
    mplr_q  <= mplr_d;
    den_q   <= den_d;
    rem_q   <= rem_d;
    dsh_q   <= dsh_d;
    quo_q   <= quo_d;
  end

  // Partial sum of the multiplier and trial subtraction of the divider.
  assign sum = acc_q + (mplr_q[0] ? {1'b0, mcand_q} : '0);
  assign ge  = (rem_q >= dsh_q);

  // Next state and datapath control.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    mcand_d = mcand_q;
    acc_d   = acc_q;
    mplr_d  = mplr_q;
    den_d   = den_q;
    rem_d   = rem_q;
    dsh_d   = dsh_q;
    quo_d   = quo_q;
    unique case (state_q)
      R_IDLE: begin
        if (start_i) begin
          mcand_d = MCAND_W'(MCAND_W'(wheel_mm_i) * MCAND_W'(WHEEL_SCALE));
          den_d   = DEN_W'(wheel_mm_i) * DEN_W'(DEN_W_SCALE)
                  + DEN_W'(interval_i) * DEN_W'(DEN_I_SCALE);
          acc_d   = '0;
          mplr_d  = interval_i;
          cnt_d   = CNT_W'(MEAS_W - 1);
          state_d = R_MUL;
        end
      end
      R_MUL: begin
        // Shift the product right one bit; the multiplier drains from the low end.
        acc_d  = {1'b0, sum[MCAND_W:1]};
        mplr_d = {sum[0], mplr_q[MEAS_W-1:1]};
        cnt_d  = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          rem_d   = {1'b0, sum[MCAND_W:1], sum[0], mplr_q[MEAS_W-1:1]};
          dsh_d   = REM_W'(den_q) << (Q_BITS - 1);
          quo_d   = '0;
          cnt_d   = CNT_W'(Q_BITS - 1);
          state_d = R_DIV;
        end
      end
      R_DIV: begin
        // One restoring step per cycle, most significant quotient bit first.
        rem_d = ge ? rem_q - dsh_q : rem_q;
        quo_d = {quo_q[Q_BITS-2:0], ge};
        dsh_d = dsh_q >> 1;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = R_DONE;
        end
      end
      R_DONE: begin
        state_d = R_IDLE;
      end
      default: begin
        state_d = R_IDLE;
      end
    endcase
  end

  // A zero divisor only occurs with a zero numerator; the result is then zero.
  assign done_o     = (state_q == R_DONE);
  assign quotient_o = (den_q == '0) ? '0 : quo_q;

endmodule

// ----- sv/wheel_pulse_rate_remapper.sv -----
// Top level of the wheel pulse rate remapper: tick stream in, one result per tick out.
// Depends on wprr_pkg, wprr_remap and assert_macros.svh.
//
// Each input transaction on s_axis is one millisecond tick; bit 0 of tdata says
// whether a magnet edge was seen in that tick. Each tick produces exactly one
// output transaction on m_axis carrying the output line level, the lamp color
// and the last measured wheel interval. Registers are written through the cfg
// channel (always ready); the user must write them only between ticks, which
// the block itself does not enforce. A tick that needs no remap passes the
// decide and due states before its result is registered for output. A remapped
// tick also waits on the serial remap unit: a start step, the shift-add multiply,
// the restoring division, a finish step and the output step.
// Ticks are handled one at a time; a new tick is accepted as soon as the
// previous result sits in the output register, even if that result has not
// yet been taken.
// Reset clears all timing state to zero, sets the next interval to 999999,
// marks an edge pending, turns the lamp green and loads default registers.
// When the receiver stalls, the result waits in the output register and a
// following tick holds in its last step until the register frees.
`include "assert_macros.svh"

module wheel_pulse_rate_remapper import wprr_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Tick stream. tdata: [0] magnet_edge, [7:1] zero.
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // Result stream. tdata: [0] pulse_level, [2:1] lamp_state,
  // [34:3] wheel_interval_ms, [39:35] zero.
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // Configuration writes.
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  // Configuration registers.
  logic [WHEEL_W-1:0]    wheel_q;
  logic [SLOW_W-1:0]     slow_q;
  logic [DEBOUNCE_W-1:0] debounce_q;
  logic [IDLE_W-1:0]     idle_q;
  logic [PULSE_W-1:0]    pulse_q;
  logic [HOLD_W-1:0]     hold_q;

  // Tick state.
  tick_state_e           state_q, state_d;
  logic [TIME_BITS-1:0]  now_q, now_d;
  logic [TIME_BITS-1:0]  last_read_q, last_read_d;
  logic [TIME_BITS-1:0]  last_write_q, last_write_d;
  logic [MEAS_W-1:0]     meas_q, meas_d;
  logic [NEXT_W-1:0]     next_q, next_d;
  logic                  pending_q, pending_d;
  logic [PULSE_W-1:0]    pulse_left_q, pulse_left_d;
  lamp_e                 lamp_q, lamp_d;
  logic                  out_valid_q, out_valid_d;
  logic [OUT_TDATA_W-1:0] out_data_q, out_data_d;

  logic                  in_fire;
  logic                  out_free;
  logic [TIME_BITS-1:0]  since_read;
  logic [TIME_BITS-1:0]  since_write;
  logic [TIME_BITS-1:0]  due;
  logic [PULSE_W-1:0]    pulse_now;
  logic                  level;
  logic                  remap_start;
  logic                  remap_done;
  logic [Q_BITS-1:0]     remap_q;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Configuration register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wheel_q    <= WHEEL_RST;
      slow_q     <= SLOW_RST;
      debounce_q <= DEBOUNCE_RST;
      idle_q     <= IDLE_RST;
      pulse_q    <= PULSE_RST;
      hold_q     <= HOLD_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_WHEEL_MM:    wheel_q    <= cfg_data_i[WHEEL_W-1:0];
        CFG_SLOW_MS:     slow_q     <= cfg_data_i[SLOW_W-1:0];
        CFG_DEBOUNCE_MS: debounce_q <= cfg_data_i[DEBOUNCE_W-1:0];
        CFG_IDLE_MS:     idle_q     <= cfg_data_i[IDLE_W-1:0];
        CFG_PULSE_MS:    pulse_q    <= cfg_data_i[PULSE_W-1:0];
        CFG_HOLD_OFF_MS: hold_q     <= cfg_data_i[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // State and timing registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      now_q        <= '0;
      last_read_q  <= '0;
      last_write_q <= '0;
      meas_q       <= '0;
      next_q       <= NEXT_RST;
      pending_q    <= 1'b1;
      pulse_left_q <= '0;
      lamp_q       <= LAMP_GREEN;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      now_q        <= now_d;
      last_read_q  <= last_read_d;
      last_write_q <= last_write_d;
      meas_q       <= meas_d;
      next_q       <= next_d;
      pending_q    <= pending_d;
      pulse_left_q <= pulse_left_d;
      lamp_q       <= lamp_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  // Time differences and the pulse deadline, all modulo the tick counter width.
  assign since_read  = now_q - last_read_q;
  assign since_write = now_q - last_write_q;
  assign due         = last_write_q + TIME_BITS'(next_q);
  assign pulse_now   = (due <= now_q) ? pulse_q : pulse_left_q;
  assign level       = (pulse_now != '0);

  // Tick sequencer: edge check, interval choice, remap wait, pulse and result.
  always_comb begin
    state_d      = state_q;
    now_d        = now_q;
    last_read_d  = last_read_q;
    last_write_d = last_write_q;
    meas_d       = meas_q;
    next_d       = next_q;
    pending_d    = pending_q;
    pulse_left_d = pulse_left_q;
    lamp_d       = lamp_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_data_d   = out_data_q;
    remap_start  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          // Accept the edge only when it lies beyond the debounce window.
          if (s_axis_tdata[0] && (since_read > TIME_BITS'(debounce_q))) begin
            meas_d      = MEAS_W'(since_read);
            last_read_d = now_q;
            pending_d   = 1'b1;
          end
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (pending_q) begin
          pending_d = 1'b0;
          if ((meas_q > MEAS_W'(slow_q)) && (since_write >= TIME_BITS'(slow_q))) begin
            // Slow wheel: pass the edge straight through.
            next_d  = '0;
            lamp_d  = LAMP_BLUE;
            state_d = S_DUE;
          end else begin
            remap_start = 1'b1;
            state_d     = S_WAIT;
          end
        end else begin
          if (since_write > TIME_BITS'(idle_q)) begin
            lamp_d = LAMP_GREEN;
          end
          state_d = S_DUE;
        end
      end
      S_WAIT: begin
        if (remap_done) begin
          next_d  = NEXT_W'(remap_q);
          lamp_d  = LAMP_RED;
          state_d = S_DUE;
        end
      end
      S_DUE: begin
        if (out_free) begin
          // Start a pulse when its deadline has passed, then emit this tick.
          if (due <= now_q) begin
            last_write_d = now_q;
            next_d       = NEXT_W'(hold_q);
          end
          pulse_left_d = level ? pulse_now - 1'b1 : '0;
          out_data_d   = OUT_TDATA_W'({meas_q, lamp_q, level});
          out_valid_d  = 1'b1;
          now_d        = now_q + 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Serial remap of the measured interval.
  wprr_remap u_remap (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (remap_start),
    .wheel_mm_i (wheel_q),
    .interval_i (meas_q),
    .done_o     (remap_done),
    .quotient_o (remap_q)
  );

  // The remap unit only finishes while the sequencer waits for it.
  `ASSERT_AT(a_done_in_wait, clk_i, rst_ni, !remap_done || (state_q == S_WAIT), "remap done outside wait")
  // A finished remap always shows the red lamp.
  `ASSERT_NEXT(a_remap_red, clk_i, rst_ni, remap_done && (state_q == S_WAIT), lamp_q == LAMP_RED, "remap without red lamp")
  // A pending edge is consumed by the interval choice.
  `ASSERT_NEXT(a_pending_used, clk_i, rst_ni, state_q == S_DECIDE, !pending_q, "pending edge kept")
  // A result held by a stalled receiver keeps the next tick in its last step.
  `ASSERT_NEXT(a_hold_due, clk_i, rst_ni, (state_q == S_DUE) && out_valid_q && !m_axis_tready, state_q == S_DUE, "result overwritten")

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench of wheel_pulse_rate_remapper: tick stream in, one checked result out.
// Depends on wprr_pkg for widths, register codes and the lamp encoding, and on the tested DUT.
module tb_top import wprr_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SETTLE_CYCLES   = 60;    // longer than a remapped tick takes
  localparam int unsigned STALL_LIMIT     = 3000;  // cycles without any transaction
  localparam int unsigned RANDOM_PHASES   = 8;
  localparam int unsigned TICKS_PER_PHASE = 100;

  typedef struct packed {
    logic                  level;
    lamp_e                 lamp;
    logic [MEAS_W-1:0]     interval;
  } tick_result_t;

  typedef struct packed {
    logic [WHEEL_W-1:0]    wheel;
    logic [SLOW_W-1:0]     slow;
    logic [DEBOUNCE_W-1:0] debounce;
    logic [IDLE_W-1:0]     idle;
    logic [PULSE_W-1:0]    pulse_len;
    logic [HOLD_W-1:0]     hold;
  } wheel_settings_t;

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_MOSTLY,
    RX_SELDOM
  } rx_mode_e;

  // Clock, reset and DUT ports.
  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // [0] magnet_edge
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [0] pulse_level, [2:1] lamp_state,
                                          // [34:3] wheel_interval_ms
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;

  // Predictor state, starting from the reset values of the block.
  wheel_settings_t     active_cfg = '{WHEEL_RST, SLOW_RST, DEBOUNCE_RST, IDLE_RST,
                                      PULSE_RST, HOLD_RST};
  logic [TIME_BITS-1:0] tick_clock      = '0;
  logic [TIME_BITS-1:0] last_edge_tick  = '0;
  logic [TIME_BITS-1:0] last_pulse_tick = '0;
  logic [MEAS_W-1:0]    wheel_period    = '0;
  logic [NEXT_W-1:0]    pulse_spacing   = NEXT_RST;
  logic                 decision_pending = 1'b1;
  logic [PULSE_W-1:0]   pulse_count     = '0;
  lamp_e                lamp_now        = LAMP_GREEN;

  tick_result_t  expected_results[$];
  int            mismatch_count = 0;
  int unsigned   burst_left = 0;
  bit            gaps_on = 1'b0;
  int unsigned   quiet_cycles = 0;
  logic [7:0]    stall_clock = '0;
  rx_mode_e      rx_mode = RX_ALWAYS;

  wheel_pulse_rate_remapper u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Remapped spacing 360*W*I / (36*W + 2000*I), truncated; a zero divisor gives zero.
  function automatic logic [NEXT_W-1:0] scaled_spacing(logic [WHEEL_W-1:0] w,
                                                      logic [MEAS_W-1:0] i);
    logic [63:0] den;
    den = 64'(DEN_W_SCALE) * 64'(w) + 64'(DEN_I_SCALE) * 64'(i);
    if (den == '0) return '0;
    return NEXT_W'((64'(WHEEL_SCALE) * 64'(w) * 64'(i)) / den);
  endfunction

  // Advances the predictor by one tick and returns the result that tick must produce.
  function automatic tick_result_t predict_tick(bit magnet);
    logic [TIME_BITS-1:0] since_edge;
    logic [TIME_BITS-1:0] since_pulse;
    logic [TIME_BITS-1:0] due_tick;
    tick_result_t         r;
    since_edge = tick_clock - last_edge_tick;
    if (magnet && since_edge > active_cfg.debounce) begin
      wheel_period     = MEAS_W'(since_edge);
      last_edge_tick   = tick_clock;
      decision_pending = 1'b1;
    end
    since_pulse = tick_clock - last_pulse_tick;
    if (decision_pending) begin
      decision_pending = 1'b0;
      if (wheel_period > active_cfg.slow && since_pulse >= active_cfg.slow) begin
        pulse_spacing = '0;
        lamp_now      = LAMP_BLUE;
      end else begin
        pulse_spacing = scaled_spacing(active_cfg.wheel, wheel_period);
        lamp_now      = LAMP_RED;
      end
    end else if (since_pulse > active_cfg.idle) begin
      lamp_now = LAMP_GREEN;
    end
    // The due sum wraps at the tick counter width.
    due_tick = last_pulse_tick + TIME_BITS'(pulse_spacing);
    if (due_tick <= tick_clock) begin
      last_pulse_tick = tick_clock;
      pulse_count     = active_cfg.pulse_len;
      pulse_spacing   = NEXT_W'(active_cfg.hold);
    end
    r.level = (pulse_count != '0);
    if (pulse_count != '0) pulse_count = pulse_count - 1'b1;
    r.lamp     = lamp_now;
    r.interval = wheel_period;
    tick_clock = tick_clock + 1'b1;
    return r;
  endfunction

  // Returns a register value: often an extreme of the field, otherwise within lo..hi.
  function automatic logic [CFG_DATA_W-1:0] pick_setting(int unsigned width,
                                                         int unsigned lo, int unsigned hi);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 12) return '0;
    if (roll < 24) return (CFG_DATA_W'(1) << width) - 1'b1;
    return CFG_DATA_W'($urandom_range(hi, lo));
  endfunction

  // One register write transaction; the caller lowers cfg_valid_i after the last one.
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (cfg_index_e'(idx))
      CFG_WHEEL_MM:    active_cfg.wheel     = value[WHEEL_W-1:0];
      CFG_SLOW_MS:     active_cfg.slow      = value[SLOW_W-1:0];
      CFG_DEBOUNCE_MS: active_cfg.debounce  = value[DEBOUNCE_W-1:0];
      CFG_IDLE_MS:     active_cfg.idle      = value[IDLE_W-1:0];
      CFG_PULSE_MS:    active_cfg.pulse_len = value[PULSE_W-1:0];
      CFG_HOLD_OFF_MS: active_cfg.hold      = value[HOLD_W-1:0];
      default: ;
    endcase
  endtask

  // Writes all six registers; only called while the block is idle.
  task automatic load_settings(wheel_settings_t s);
    cfg_write(CFG_WHEEL_MM,    CFG_DATA_W'(s.wheel));
    cfg_write(CFG_SLOW_MS,     CFG_DATA_W'(s.slow));
    cfg_write(CFG_DEBOUNCE_MS, CFG_DATA_W'(s.debounce));
    cfg_write(CFG_IDLE_MS,     CFG_DATA_W'(s.idle));
    cfg_write(CFG_PULSE_MS,    CFG_DATA_W'(s.pulse_len));
    cfg_write(CFG_HOLD_OFF_MS, CFG_DATA_W'(s.hold));
    cfg_valid_i <= 1'b0;
  endtask

  // Sends one tick transaction, inserting a random gap (when gaps are on) at the start of each burst.
  task automatic send_tick(bit magnet);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(24, 1);
      gap = gaps_on ? $urandom_range(8) : 0;
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'(magnet);
    do @(posedge clk_i); while (!s_axis_tready);
    expected_results.push_back(predict_tick(magnet));
  endtask

  // Sends count ticks whose magnet flags are taken from bits, lowest bit first.
  task automatic send_pattern(logic [15:0] bits, int unsigned count);
    for (int unsigned n = 0; n < count; n++) send_tick(bits[n]);
  endtask

  // Holds the sender until every expected result has arrived and the block has settled.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // All registers at zero: zero divisor on the first tick, an edge on tick zero,
  // pulses of zero length every tick, lamp idle at once. Unused indexes are ignored.
  task automatic test_zero_settings();
    for (int idx = int'(CFG_HOLD_OFF_MS) + 1; idx < (1 << CFG_IDX_W); idx++)
      cfg_write(CFG_IDX_W'(idx), $urandom());
    load_settings('0);
    send_pattern(16'b1010_1101, 8);
    wait_drained();
  endtask

  // All registers at their field maxima: long debounce swallows every edge.
  task automatic test_register_maxima();
    load_settings('1);
    send_pattern(16'hFFFF, 8);
    wait_drained();
  endtask

  // Hold-off of one tick restarts pulses while high; a low threshold passes edges through.
  task automatic test_retrigger_and_slow();
    wheel_settings_t s;
    s = '{WHEEL_W'(500), SLOW_W'(1), DEBOUNCE_W'(1), IDLE_W'(3), PULSE_W'(4), HOLD_W'(1)};
    load_settings(s);
    send_pattern(16'b1_1000_1101, 9);
    wait_drained();
  endtask

  // Random settings per phase with random edge density; one phase pauses mid-way.
  task automatic test_random_settings();
    wheel_settings_t s;
    int unsigned     edge_pct;
    for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
      s.wheel     = WHEEL_W'(pick_setting(WHEEL_W, 500, 4000));
      s.slow      = SLOW_W'(pick_setting(SLOW_W, 1, 120));
      s.debounce  = DEBOUNCE_W'(pick_setting(DEBOUNCE_W, 0, 40));
      s.idle      = IDLE_W'(pick_setting(IDLE_W, 0, 200));
      s.pulse_len = PULSE_W'(pick_setting(PULSE_W, 1, 12));
      s.hold      = HOLD_W'(pick_setting(HOLD_W, 1, 150));
      load_settings(s);
      edge_pct   = $urandom_range(60, 5);
      gaps_on    = ($urandom_range(9) < 7);
      burst_left = 0;
      for (int unsigned n = 0; n < TICKS_PER_PHASE; n++) begin
        send_tick($urandom_range(99) < edge_pct);
        if (phase == 2 && n == TICKS_PER_PHASE / 2) wait_drained();
      end
      wait_drained();
    end
  endtask

  // Stimulus sequence and final verdict.
  initial begin
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= '0;
    cfg_data_i    <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_zero_settings();
    test_register_maxima();
    test_retrigger_and_slow();
    test_random_settings();
    if (mismatch_count == 0)
      $display("[wheel_pulse_rate_remapper] OK");
    else
      $display("[wheel_pulse_rate_remapper] ERROR");
    $finish;
  end

  // Receiver readiness picks a new random pattern each time the stall clock wraps to zero.
  always @(posedge clk_i) begin
    stall_clock <= stall_clock + 1'b1;
    if (stall_clock == '0) rx_mode <= rx_mode_e'($urandom_range(2));
    case (rx_mode)
      RX_ALWAYS: m_axis_tready <= 1'b1;
      RX_MOSTLY: m_axis_tready <= ($urandom_range(3) != 0);
      default:   m_axis_tready <= ($urandom_range(3) == 0);
    endcase
  end

  // Compares each result transaction with the oldest expectation.
  always @(posedge clk_i) begin : check_results
    tick_result_t want;
    lamp_e        got_lamp;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_lamp = lamp_e'(m_axis_tdata[2:1]);
      if (expected_results.size() == 0) begin
        $display("%0t: result with no tick waiting, tdata %h", $time, m_axis_tdata);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tdata[0] !== want.level) begin
          $display("%0t: pulse_level expected %0d, got %0d", $time, want.level,
                   m_axis_tdata[0]);
          mismatch_count++;
        end
        if (got_lamp !== want.lamp) begin
          $display("%0t: lamp_state expected %0d, got %0d", $time, want.lamp, got_lamp);
          mismatch_count++;
        end
        if (m_axis_tdata[34:3] !== want.interval) begin
          $display("%0t: wheel_interval_ms expected %0d, got %0d", $time, want.interval,
                   m_axis_tdata[34:3]);
          mismatch_count++;
        end
      end
    end
  end

  // Ends the run when no transaction of any kind has happened for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("[wheel_pulse_rate_remapper] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/wprr_pkg.sv
sv/wprr_remap.sv
sv/wheel_pulse_rate_remapper.sv
verif/tb_top.sv
